// File: rtl/mavt_pkg.sv
// Shared types, constants and register codes for the multiturn angle tracker.
// No dependencies; every other file in rtl/ uses this package.
package mavt_pkg;

    localparam int ANGLE_BITS_DEF   = 14;
    localparam int STAMP_BITS_DEF   = 32;
    localparam int ANGLE_FIELD_BITS = 14;
    localparam int STAMP_FIELD_BITS = 32;
    localparam int TURN_BITS        = 32;
    localparam int VEL_BITS         = 32;
    localparam int RATE_BITS        = 27;
    localparam int MIN_EL_BITS      = 32;
    localparam int WRAP_BITS        = 14;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int CFG_DATA_BITS    = 32;
    localparam int QUO_BITS         = 31;
    localparam int STEP_BITS        = $clog2(QUO_BITS);

    localparam logic [CFG_INDEX_BITS-1:0] REG_TICK_RATE   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_ELAPSED = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WRAP_THR    = 2'd2;

    localparam logic [RATE_BITS-1:0]   TICK_RATE_RST   = 27'd10000000;
    localparam logic [MIN_EL_BITS-1:0] MIN_ELAPSED_RST = 32'd1000;
    localparam logic [WRAP_BITS-1:0]   WRAP_THR_RST    = 14'd13107;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam logic [VEL_BITS-1:0] VEL_MAX = 32'h7FFF_FFFF;
    localparam logic [VEL_BITS-1:0] VEL_MIN = 32'h8000_0000;

    typedef struct packed {
        logic                        kind;
        logic [ANGLE_FIELD_BITS-1:0] sample_angle;
        logic                        sample_invalid;
        logic [STAMP_FIELD_BITS-1:0] timestamp;
    } t_in_item;

    typedef struct packed {
        logic signed [TURN_BITS-1:0] turn_count;
        logic [ANGLE_FIELD_BITS-1:0] angle_now;
        logic signed [VEL_BITS-1:0]  velocity;
        logic                        velocity_fresh;
        logic                        sample_taken;
    } t_out_item;

    typedef struct packed {
        logic [RATE_BITS-1:0]   tick_rate_hz;
        logic [MIN_EL_BITS-1:0] min_elapsed_ticks;
        logic [WRAP_BITS-1:0]   wrap_threshold;
    } t_cfg;

endpackage

// File: rtl/mavt_ifs.sv
// Valid/ready channel interfaces: sample/query input, result output, config write.
// Depends on mavt_pkg for payload types and widths.
interface mavt_in_if;
    import mavt_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mavt_out_if;
    import mavt_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mavt_cfg_if;
    import mavt_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/mavt_cfg_regs.sv
// Configuration register file: tick rate, minimum elapsed ticks, wrap threshold.
// Depends on mavt_pkg and mavt_cfg_if.
module mavt_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mavt_cfg_if.sink       i_cfg,
    output mavt_pkg::t_cfg o_cfg
);
    import mavt_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_TICK_RATE:   n_cfg.tick_rate_hz      = i_cfg.wdata[RATE_BITS-1:0];
                REG_MIN_ELAPSED: n_cfg.min_elapsed_ticks = i_cfg.wdata[MIN_EL_BITS-1:0];
                REG_WRAP_THR:    n_cfg.wrap_threshold    = i_cfg.wdata[WRAP_BITS-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_rate_hz      <= TICK_RATE_RST;
            r_cfg.min_elapsed_ticks <= MIN_ELAPSED_RST;
            r_cfg.wrap_threshold    <= WRAP_THR_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: rtl/mavt_serial_muldiv.sv
// Bit-serial velocity unit: signed numerator, shift-add multiply by tick rate,
// overflow check, then restoring divide by elapsed ticks, one bit per cycle.
// Depends on mavt_pkg.
module mavt_serial_muldiv #(
    parameter int ANGLE_BITS = mavt_pkg::ANGLE_BITS_DEF,
    parameter int STAMP_BITS = mavt_pkg::STAMP_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [mavt_pkg::TURN_BITS-1:0]   i_turns,
    input  logic [mavt_pkg::TURN_BITS-1:0]   i_ref_turns,
    input  logic [ANGLE_BITS-1:0]            i_angle,
    input  logic [ANGLE_BITS-1:0]            i_ref_angle,
    input  logic [STAMP_BITS-1:0]            i_elapsed,
    input  logic [mavt_pkg::RATE_BITS-1:0]   i_rate,
    output logic                             o_done,
    output logic [mavt_pkg::VEL_BITS-1:0]    o_velocity
);
    import mavt_pkg::*;

    localparam int AW = ANGLE_BITS;
    localparam int SW = STAMP_BITS;
    localparam int MW = TURN_BITS + AW;
    localparam int NW = MW + 1;
    localparam int PW = MW + RATE_BITS;
    localparam int HW = PW - QUO_BITS;

    typedef enum logic [6:0] {
        U_IDLE = 7'b0000001,
        U_NUM  = 7'b0000010,
        U_ABS  = 7'b0000100,
        U_MUL  = 7'b0001000,
        U_CHK  = 7'b0010000,
        U_DIV  = 7'b0100000,
        U_DONE = 7'b1000000
    } t_md_state;

    t_md_state             r_state, n_state;
    logic [TURN_BITS-1:0]  r_dt,    n_dt;
    logic [AW:0]           r_da,    n_da;
    logic [NW-1:0]         r_num,   n_num;
    logic                  r_neg,   n_neg;
    logic [MW-1:0]         r_mag,   n_mag;
    logic [RATE_BITS-1:0]  r_rate,  n_rate;
    logic [SW-1:0]         r_den,   n_den;
    logic [PW-1:0]         r_acc,   n_acc;
    logic [SW-1:0]         r_rem,   n_rem;
    logic [QUO_BITS-1:0]   r_quo,   n_quo;
    logic                  r_sat,   n_sat;
    logic [STEP_BITS-1:0]  r_cnt,   n_cnt;

    logic [NW-1:0]         num_w;
    logic [NW-1:0]         num_neg;
    logic [PW-1:0]         addend;
    logic [HW-1:0]         hi;
    logic [HW-1:0]         den_hi;
    logic [SW:0]           trial;
    logic [SW:0]           den_ext;
    logic                  ge;
    logic [VEL_BITS-1:0]   q_ext;

    always_comb begin
        num_w   = {r_dt[TURN_BITS-1], r_dt, {AW{1'b0}}}
                + {{(NW-AW-1){r_da[AW]}}, r_da};
        num_neg = ~r_num + 1'b1;
        addend  = r_rate[RATE_BITS-1] ? {{RATE_BITS{1'b0}}, r_mag} : '0;
        hi      = r_acc[PW-1:QUO_BITS];
        den_hi  = {{(HW-SW){1'b0}}, r_den};
        trial   = {r_rem, r_acc[QUO_BITS-1]};
        den_ext = {1'b0, r_den};
        ge      = (trial >= den_ext);
        q_ext   = {1'b0, r_quo};

        n_state = r_state;
        n_dt    = r_dt;
        n_da    = r_da;
        n_num   = r_num;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_rate  = r_rate;
        n_den   = r_den;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_sat   = r_sat;
        n_cnt   = r_cnt;

        case (r_state)
            U_IDLE: begin
                if (i_start) begin
                    n_dt    = i_turns - i_ref_turns;
                    n_da    = {1'b0, i_angle} - {1'b0, i_ref_angle};
                    n_rate  = i_rate;
                    n_den   = i_elapsed;
                    n_state = U_NUM;
                end
            end
            U_NUM: begin
                n_num   = num_w;
                n_neg   = num_w[NW-1];
                n_state = U_ABS;
            end
            U_ABS: begin
                n_mag   = r_neg ? num_neg[MW-1:0] : r_num[MW-1:0];
                n_acc   = '0;
                n_cnt   = '0;
                n_sat   = 1'b0;
                n_quo   = '0;
                n_state = U_MUL;
            end
            U_MUL: begin
                n_acc  = {r_acc[PW-2:0], 1'b0} + addend;
                n_rate = {r_rate[RATE_BITS-2:0], 1'b0};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == STEP_BITS'(RATE_BITS - 1)) begin
                    n_state = U_CHK;
                end
            end
            U_CHK: begin
                n_cnt = '0;
                if (hi >= den_hi) begin
                    n_sat   = 1'b1;
                    n_state = U_DONE;
                end else begin
                    n_rem   = hi[SW-1:0];
                    n_state = U_DIV;
                end
            end
            U_DIV: begin
                n_rem = ge ? SW'(trial - den_ext) : trial[SW-1:0];
                n_quo = {r_quo[QUO_BITS-2:0], ge};
                n_acc = {r_acc[PW-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_BITS'(QUO_BITS - 1)) begin
                    n_state = U_DONE;
                end
            end
            U_DONE: begin
                n_state = U_IDLE;
            end
            default: begin
                n_state = U_IDLE;
            end
        endcase
    end

    assign o_done = (r_state == U_DONE);

    always_comb begin
        if (r_neg) begin
            o_velocity = r_sat ? VEL_MIN : (~q_ext + 1'b1);
        end else begin
            o_velocity = r_sat ? VEL_MAX : q_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dt   <= n_dt;
        r_da   <= n_da;
        r_num  <= n_num;
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_rate <= n_rate;
        r_den  <= n_den;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_sat  <= n_sat;
        r_cnt  <= n_cnt;
    end

endmodule

// File: rtl/multiturn_angle_velocity_tracker.sv
// Multiturn angle tracker and velocity estimator, top level.
// Depends on mavt_pkg, mavt_ifs, mavt_cfg_regs and mavt_serial_muldiv.
//
// Usage:
//   i_in  : one item per transfer. kind 0 is an angle sample (angle, invalid
//           flag, timestamp), kind 1 is a velocity query. One result per item.
//   o_out : turn count, latest angle, velocity, fresh and sample-taken flags.
//   i_cfg : register writes (0 tick rate, 1 minimum elapsed ticks, 2 wrap
//           threshold); always ready, other indexes are dropped.
// Flow:
//   Items are processed one at a time. A sample, or a query answered from the
//   held velocity, goes through the execute and finish states to the output
//   register. A query that recomputes also waits in S_WAIT for the bit-serial
//   unit: setup, 27 multiply steps (one tick-rate bit each), an overflow check,
//   31 divide steps (one quotient bit each) and handoff; a saturating result
//   skips the divide steps. i_in is ready again the cycle after a result is
//   loaded into the output register, and no new item is taken before then.
// Reset: synchronous, active low. All tracking state clears, registers load
//   their reset values, no result is pending.
// Stall: a result waits in the output register until taken; the next item is
//   still accepted and processed up to its own result.
module multiturn_angle_velocity_tracker #(
    parameter int ANGLE_BITS = mavt_pkg::ANGLE_BITS_DEF,
    parameter int STAMP_BITS = mavt_pkg::STAMP_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mavt_in_if.sink     i_in,
    mavt_out_if.source  o_out,
    mavt_cfg_if.sink    i_cfg
);
    import mavt_pkg::*;

    localparam int AW = ANGLE_BITS;
    localparam int SW = STAMP_BITS;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WAIT = 4'b0100,
        S_FIN  = 4'b1000
    } t_trk_state;

    t_cfg                 cfg;
    t_trk_state           r_state, n_state;

    logic                 r_kind;
    logic [AW-1:0]        r_angle;
    logic                 r_invalid;
    logic [SW-1:0]        r_stamp;

    logic [AW-1:0]        r_last_angle, n_last_angle;
    logic [SW-1:0]        r_last_stamp, n_last_stamp;
    logic [TURN_BITS-1:0] r_turns,      n_turns;
    logic [AW-1:0]        r_ref_angle,  n_ref_angle;
    logic [TURN_BITS-1:0] r_ref_turns,  n_ref_turns;
    logic [SW-1:0]        r_ref_stamp,  n_ref_stamp;
    logic [VEL_BITS-1:0]  r_held_vel,   n_held_vel;
    logic                 r_primed,     n_primed;
    logic                 r_fresh,      n_fresh;
    logic                 r_taken,      n_taken;

    logic                 r_out_valid,  n_out_valid;
    t_out_item            r_out,        n_out;

    logic [31:0]          angle_in32;
    logic [31:0]          angle_out32;
    logic [SW-1:0]        elapsed;
    logic                 el_neg;
    logic                 el_short;
    logic [AW:0]          d;
    logic [AW:0]          ad;
    logic                 md_start;
    logic                 md_done;
    logic [VEL_BITS-1:0]  md_vel;
    logic                 out_load;

    mavt_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    mavt_serial_muldiv #(
        .ANGLE_BITS (ANGLE_BITS),
        .STAMP_BITS (STAMP_BITS)
    ) u_muldiv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (md_start),
        .i_turns     (r_turns),
        .i_ref_turns (r_ref_turns),
        .i_angle     (r_last_angle),
        .i_ref_angle (r_ref_angle),
        .i_elapsed   (elapsed),
        .i_rate      (cfg.tick_rate_hz),
        .o_done      (md_done),
        .o_velocity  (md_vel)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign angle_in32  = 32'(i_in.data.sample_angle);
    assign angle_out32 = 32'(r_last_angle);
    assign elapsed     = r_last_stamp - r_ref_stamp;
    assign el_neg      = elapsed[SW-1];
    assign el_short    = (32'(elapsed) < cfg.min_elapsed_ticks) || (elapsed == '0);
    assign d           = {1'b0, r_angle} - {1'b0, r_last_angle};
    assign ad          = d[AW] ? (~d + 1'b1) : d;
    assign md_start    = (r_state == S_EXEC) && (r_kind == KIND_QUERY) && !el_neg && !el_short;
    assign out_load    = (r_state == S_FIN) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state      = r_state;
        n_last_angle = r_last_angle;
        n_last_stamp = r_last_stamp;
        n_turns      = r_turns;
        n_ref_angle  = r_ref_angle;
        n_ref_turns  = r_ref_turns;
        n_ref_stamp  = r_ref_stamp;
        n_held_vel   = r_held_vel;
        n_primed     = r_primed;
        n_fresh      = r_fresh;
        n_taken      = r_taken;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_fresh = 1'b0;
                n_taken = 1'b0;
                n_state = S_FIN;
                if (r_kind == KIND_SAMPLE) begin
                    if (!r_invalid) begin
                        n_taken      = 1'b1;
                        n_last_angle = r_angle;
                        n_last_stamp = r_stamp;
                        if (!r_primed) begin
                            n_ref_angle = r_angle;
                            n_ref_turns = r_turns;
                            n_ref_stamp = r_stamp;
                            n_primed    = 1'b1;
                        end else if (32'(ad) > 32'(cfg.wrap_threshold)) begin
                            n_turns = d[AW] ? (r_turns + 1'b1) : (r_turns - 1'b1);
                        end
                    end
                end else if (el_neg) begin
                    n_ref_angle = r_last_angle;
                    n_ref_turns = r_turns;
                    n_ref_stamp = r_last_stamp;
                end else if (!el_short) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (md_done) begin
                    n_held_vel  = md_vel;
                    n_fresh     = 1'b1;
                    n_ref_angle = r_last_angle;
                    n_ref_turns = r_turns;
                    n_ref_stamp = r_last_stamp;
                    n_state     = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out                = r_out;
        n_out_valid          = r_out_valid;
        if (out_load) begin
            n_out.turn_count     = r_turns;
            n_out.angle_now      = angle_out32[ANGLE_FIELD_BITS-1:0];
            n_out.velocity       = r_held_vel;
            n_out.velocity_fresh = r_fresh;
            n_out.sample_taken   = r_taken;
            n_out_valid          = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_last_angle <= '0;
            r_last_stamp <= '0;
            r_turns      <= '0;
            r_ref_angle  <= '0;
            r_ref_turns  <= '0;
            r_ref_stamp  <= '0;
            r_held_vel   <= '0;
            r_primed     <= 1'b0;
            r_fresh      <= 1'b0;
            r_taken      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_last_angle <= n_last_angle;
            r_last_stamp <= n_last_stamp;
            r_turns      <= n_turns;
            r_ref_angle  <= n_ref_angle;
            r_ref_turns  <= n_ref_turns;
            r_ref_stamp  <= n_ref_stamp;
            r_held_vel   <= n_held_vel;
            r_primed     <= n_primed;
            r_fresh      <= n_fresh;
            r_taken      <= n_taken;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_in.valid && i_in.ready) begin
            r_kind    <= i_in.data.kind;
            r_angle   <= angle_in32[AW-1:0];
            r_invalid <= i_in.data.sample_invalid;
            r_stamp   <= i_in.data.timestamp[SW-1:0];
        end
    end

endmodule

// File: rtl/mavt_checker.sv
// Port-level checker for the multiturn angle tracker, bound to the top level.
// Depends on multiturn_angle_velocity_tracker and mavt_pkg widths.
module mavt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic                            i_out_fresh,
    input logic                            i_out_taken,
    input logic [mavt_pkg::VEL_BITS-1:0]   i_out_velocity,
    input logic [mavt_pkg::TURN_BITS-1:0]  i_out_turns
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_velocity) && $stable(i_out_turns))
        else $error("result payload changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item taken while one is in flight");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_fresh && i_out_taken))
        else $error("fresh velocity and sample taken on the same result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending after reset");

endmodule

bind multiturn_angle_velocity_tracker mavt_checker u_mavt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_fresh    (o_out.data.velocity_fresh),
    .i_out_taken    (o_out.data.sample_taken),
    .i_out_velocity (o_out.data.velocity),
    .i_out_turns    (o_out.data.turn_count)
);

// File: dv/multiturn_angle_velocity_tracker_tb.sv
// Testbench for multiturn_angle_velocity_tracker: a directed table, then random samples and queries.
// Results are checked against an in-file turn/velocity predictor, with random idling on both sides.
// Depends on mavt_pkg, the mavt_ifs interfaces and the RTL under rtl/.
module multiturn_angle_velocity_tracker_tb;
    import mavt_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;
    localparam int NUM_RANDOM    = 1750;
    localparam int NUM_PHASES    = 7;
    localparam int MAX_GAP       = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 100;
    localparam int IDLE_LIMIT    = 4000;

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_QUERY, ROW_CFG} t_row_op;

    typedef struct packed {
        t_row_op                     op;
        logic [CFG_INDEX_BITS-1:0]   reg_idx;
        logic [ANGLE_FIELD_BITS-1:0] angle;
        logic                        invalid;
        logic [31:0]                 value;   // timestamp, or register data
        logic                        typed;
        t_out_item                   result;
    } t_stim_row;

    localparam t_out_item NO_RESULT = '0;
    localparam int NUM_ROWS = 35;
    localparam t_stim_row DIRECTED [NUM_ROWS] = '{
        '{ROW_QUERY,  REG_SPARE, 14'd0,     1'b0, 32'd0,          1'b1,
          '{32'sd0, 14'd0, 32'sd0, 1'b0, 1'b0}},
        '{ROW_SAMPLE, REG_SPARE, 14'd16383, 1'b1, 32'hFFFF_FFFF,  1'b1,
          '{32'sd0, 14'd0, 32'sd0, 1'b0, 1'b0}},
        '{ROW_SAMPLE, REG_SPARE, 14'd16383, 1'b0, 32'd0,          1'b1,
          '{32'sd0, 14'd16383, 32'sd0, 1'b0, 1'b1}},
        '{ROW_SAMPLE, REG_SPARE, 14'd0,     1'b0, 32'd1000,       1'b1,
          '{32'sd1, 14'd0, 32'sd0, 1'b0, 1'b1}},
        '{ROW_QUERY,  REG_SPARE, 14'd0,     1'b0, 32'd0,          1'b0, NO_RESULT},
        '{ROW_SAMPLE, REG_SPARE, 14'd16383, 1'b0, 32'd1500,       1'b0, NO_RESULT},
        '{ROW_QUERY,  REG_SPARE, 14'd0,     1'b0, 32'd0,          1'b0, NO_RESULT},
        '{ROW_SAMPLE, REG_SPARE, 14'd3000,  1'b0, 32'd2000,       1'b0, NO_RESULT},
        '{ROW_SAMPLE, REG_SPARE, 14'd16110, 1'b0, 32'd2500,       1'b0, NO_RESULT},
        '{ROW_SAMPLE, REG_SPARE, 14'd3003,  1'b0, 32'd3000,       1'b0, NO_RESULT},
        '{ROW_QUERY,  REG_SPARE, 14'd0,     1'b0, 32'd0,          1'b0, NO_RESULT},
        '{ROW_SAMPLE, REG_SPARE, 14'd100,   1'b0, 32'hFFFF_F000,  1'b0, NO_RESULT},
        '{ROW_QUERY,  REG_SPARE, 14'd0,     1'b0, 32'd0,          1'b0, NO_RESULT},
        '{ROW_QUERY,  REG_SPARE, 14'd16383, 1'b1, 32'hFFFF_FFFF,  1'b0, NO_RESULT},
        '{ROW_CFG,    REG_MIN_ELAPSED, 14'd0, 1'b0, 32'd0,        1'b0, NO_RESULT},
        '{ROW_CFG,    REG_WRAP_THR,    14'd0, 1'b0, 32'd0,        1'b0, NO_RESULT},
        '{ROW_CFG,    REG_TICK_RATE,   14'd0, 1'b0, 32'd100000000, 1'b0, NO_RESULT},
        '{ROW_CFG,    REG_SPARE,       14'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_SAMPLE, REG_SPARE, 14'd16383, 1'b0, 32'hFFFF_F001,  1'b0, NO_RESULT},
        '{ROW_QUERY,  REG_SPARE, 14'd0,     1'b0, 32'd0,          1'b0, NO_RESULT},
        '{ROW_CFG,    REG_WRAP_THR,    14'd0, 1'b0, 32'd16383,    1'b0, NO_RESULT},
        '{ROW_CFG,    REG_MIN_ELAPSED, 14'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_SAMPLE, REG_SPARE, 14'd0,     1'b0, 32'd0,          1'b0, NO_RESULT},
        '{ROW_QUERY,  REG_SPARE, 14'd0,     1'b0, 32'd0,          1'b0, NO_RESULT},
        '{ROW_CFG,    REG_MIN_ELAPSED, 14'd0, 1'b0, 32'd0,        1'b0, NO_RESULT},
        '{ROW_SAMPLE, REG_SPARE, 14'd16383, 1'b0, 32'd1,          1'b0, NO_RESULT},
        '{ROW_QUERY,  REG_SPARE, 14'd0,     1'b0, 32'd0,          1'b0, NO_RESULT},
        '{ROW_SAMPLE, REG_SPARE, 14'd0,     1'b0, 32'd2,          1'b0, NO_RESULT},
        '{ROW_QUERY,  REG_SPARE, 14'd0,     1'b0, 32'd0,          1'b0, NO_RESULT},
        '{ROW_SAMPLE, REG_SPARE, 14'd16383, 1'b0, 32'd3,          1'b0, NO_RESULT},
        '{ROW_QUERY,  REG_SPARE, 14'd0,     1'b0, 32'd0,          1'b0, NO_RESULT},
        '{ROW_CFG,    REG_TICK_RATE,   14'd0, 1'b0, 32'd0,        1'b0, NO_RESULT},
        '{ROW_SAMPLE, REG_SPARE, 14'd0,     1'b0, 32'd4,          1'b0, NO_RESULT},
        '{ROW_QUERY,  REG_SPARE, 14'd0,     1'b0, 32'd0,          1'b0, NO_RESULT},
        '{ROW_CFG,    REG_TICK_RATE,   14'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, NO_RESULT}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    mavt_in_if  in_if ();
    mavt_out_if out_if ();
    mavt_cfg_if cfg_if ();

    multiturn_angle_velocity_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #5 i_clk = ~i_clk;

    // tracker state mirrored for prediction
    t_cfg                        cfg_model;
    logic [ANGLE_FIELD_BITS-1:0] cur_angle;
    logic [STAMP_FIELD_BITS-1:0] cur_stamp;
    logic [TURN_BITS-1:0]        turn_acc;
    logic [ANGLE_FIELD_BITS-1:0] base_angle;
    logic [TURN_BITS-1:0]        base_turns;
    logic [STAMP_FIELD_BITS-1:0] base_stamp;
    logic [VEL_BITS-1:0]         held_vel;
    logic                        primed;

    t_out_item expected_reports[$];
    int        errors      = 0;
    int        idle_cycles = 0;
    bit        in_calm     = 1'b0;
    bit        out_calm    = 1'b0;

    function automatic void rebase_reference();
        base_angle = cur_angle;
        base_turns = turn_acc;
        base_stamp = cur_stamp;
    endfunction

    function automatic t_out_item track_item(input t_in_item it);
        t_out_item                   res;
        int                          jump;
        int                          jump_mag;
        logic [STAMP_FIELD_BITS-1:0] elapsed;
        logic signed [TURN_BITS-1:0] turn_diff;
        longint                      travel;
        longint unsigned             travel_mag;
        longint unsigned             quo;
        longint unsigned             rem;
        longint unsigned             rate;
        longint unsigned             speed;
        res = '0;
        if (it.kind == KIND_SAMPLE) begin
            if (!it.sample_invalid) begin
                res.sample_taken = 1'b1;
                if (primed) begin
                    jump     = int'(it.sample_angle) - int'(cur_angle);
                    jump_mag = (jump < 0) ? -jump : jump;
                    if (jump_mag > int'(cfg_model.wrap_threshold))
                        turn_acc = (jump > 0) ? turn_acc - 1 : turn_acc + 1;
                end
                cur_angle = it.sample_angle;
                cur_stamp = it.timestamp;
                if (!primed) begin
                    rebase_reference();
                    primed = 1'b1;
                end
            end
        end else begin
            elapsed = cur_stamp - base_stamp;
            if (elapsed[STAMP_FIELD_BITS-1]) begin
                rebase_reference();
            end else if (elapsed != 0 && elapsed >= cfg_model.min_elapsed_ticks) begin
                turn_diff  = turn_acc - base_turns;
                travel     = longint'(turn_diff);
                travel     = travel * (1 << ANGLE_FIELD_BITS)
                           + longint'(cur_angle) - longint'(base_angle);
                travel_mag = (travel < 0) ? -travel : travel;
                quo        = travel_mag / elapsed;
                rem        = travel_mag % elapsed;
                rate       = 64'(cfg_model.tick_rate_hz);
                if (rate != 0 && quo > 64'h1_0000_0000)
                    speed = 64'h1_0000_0000;
                else
                    speed = quo * rate + (rem * rate) / elapsed;
                if (travel < 0)
                    held_vel = (speed >= 64'h8000_0000) ? VEL_MIN : 32'h0 - speed[31:0];
                else
                    held_vel = (speed >= 64'h7FFF_FFFF) ? VEL_MAX : speed[31:0];
                res.velocity_fresh = 1'b1;
                rebase_reference();
            end
        end
        res.turn_count = turn_acc;
        res.angle_now  = cur_angle;
        res.velocity   = held_vel;
        return res;
    endfunction

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item typed_res);
        int        gap;
        t_out_item predicted;
        if ($urandom_range(0, 39) == 0)
            in_calm = !in_calm;
        gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (!in_if.ready);
        predicted = track_item(it);
        expected_reports.push_back(typed ? typed_res : predicted);
    endtask

    // block is idle once every result has been taken
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.wdata <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_TICK_RATE:   cfg_model.tick_rate_hz      = data[RATE_BITS-1:0];
            REG_MIN_ELAPSED: cfg_model.min_elapsed_ticks = data[MIN_EL_BITS-1:0];
            REG_WRAP_THR:    cfg_model.wrap_threshold    = data[WRAP_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    initial begin : stimulus
        t_stim_row                   row;
        t_in_item                    item;
        logic [ANGLE_FIELD_BITS-1:0] angle_cursor;
        logic [STAMP_FIELD_BITS-1:0] stamp_cursor;
        int                          pick;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= REG_TICK_RATE;
        cfg_if.wdata <= '0;
        i_rst_n      <= 1'b0;
        cfg_model    = '{TICK_RATE_RST, MIN_ELAPSED_RST, WRAP_THR_RST};
        cur_angle    = '0;
        cur_stamp    = '0;
        turn_acc     = '0;
        base_angle   = '0;
        base_turns   = '0;
        base_stamp   = '0;
        held_vel     = '0;
        primed       = 1'b0;
        angle_cursor = '0;
        stamp_cursor = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            row = DIRECTED[r];
            if (row.op == ROW_CFG) begin
                drain_results();
                write_reg(row.reg_idx, row.value);
            end else begin
                item.kind           = (row.op == ROW_QUERY) ? KIND_QUERY : KIND_SAMPLE;
                item.sample_angle   = row.angle;
                item.sample_invalid = row.invalid;
                item.timestamp      = row.value;
                send_item(item, row.typed, row.result);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            case ($urandom_range(0, 3))
                0:       write_reg(REG_TICK_RATE, 32'(TICK_RATE_RST));
                1:       write_reg(REG_TICK_RATE, 32'd1);
                2:       write_reg(REG_TICK_RATE, 32'd100000000);
                default: write_reg(REG_TICK_RATE, $urandom);
            endcase
            case ($urandom_range(0, 7))
                0:       write_reg(REG_MIN_ELAPSED, 32'd0);
                1:       write_reg(REG_MIN_ELAPSED, $urandom);
                2, 3:    write_reg(REG_MIN_ELAPSED, $urandom_range(0, 500));
                default: write_reg(REG_MIN_ELAPSED, $urandom_range(0, 5000));
            endcase
            case ($urandom_range(0, 4))
                0:       write_reg(REG_WRAP_THR, 32'd0);
                1:       write_reg(REG_WRAP_THR, 32'd16383);
                2:       write_reg(REG_WRAP_THR, 32'(WRAP_THR_RST));
                default: write_reg(REG_WRAP_THR, $urandom_range(0, 16383));
            endcase
            for (int n = 0; n < NUM_RANDOM / NUM_PHASES; n++) begin
                if ($urandom_range(0, 99) == 0)
                    drain_results();
                item.kind           = KIND_SAMPLE;
                item.sample_invalid = 1'b0;
                item.sample_angle   = ANGLE_FIELD_BITS'($urandom);
                item.timestamp      = $urandom;
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    item.kind           = KIND_QUERY;
                    item.sample_invalid = 1'($urandom_range(0, 1));
                end else if (pick < 32) begin
                    item.sample_invalid = 1'b1;
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60)
                        angle_cursor = ANGLE_FIELD_BITS'(angle_cursor
                                     + $urandom_range(0, 1200) - 600);
                    else if (pick < 85)
                        angle_cursor = ANGLE_FIELD_BITS'(angle_cursor
                                     + $urandom_range(0, 16383));
                    else
                        angle_cursor = ANGLE_FIELD_BITS'($urandom);
                    pick = $urandom_range(0, 99);
                    if (pick < 80)
                        stamp_cursor = stamp_cursor + $urandom_range(0, 4000);
                    else if (pick < 88)
                        stamp_cursor = stamp_cursor + $urandom_range(0, 200000);
                    else if (pick < 94)
                        stamp_cursor = stamp_cursor - $urandom_range(1, 5000);
                    else
                        stamp_cursor = $urandom;
                    item.sample_angle = angle_cursor;
                    item.timestamp    = stamp_cursor;
                end
                send_item(item, 1'b0, NO_RESULT);
            end
        end

        in_if.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin : result_check
        t_out_item got;
        t_out_item want;
        int        stall;
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0)
                out_calm = !out_calm;
            stall = out_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            got = out_if.data;
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, got turns %0d angle %0d vel %0d",
                         $time, got.turn_count, got.angle_now, got.velocity);
                errors++;
            end else begin
                want = expected_reports.pop_front();
                check_field("turn_count",     want.turn_count,     got.turn_count);
                check_field("angle_now",      want.angle_now,      got.angle_now);
                check_field("velocity",       want.velocity,       got.velocity);
                check_field("velocity_fresh", want.velocity_fresh, got.velocity_fresh);
                check_field("sample_taken",   want.sample_taken,   got.sample_taken);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

// File: filelist.f
rtl/mavt_pkg.sv
rtl/mavt_ifs.sv
rtl/mavt_cfg_regs.sv
rtl/mavt_serial_muldiv.sv
rtl/multiturn_angle_velocity_tracker.sv
rtl/mavt_checker.sv
dv/multiturn_angle_velocity_tracker_tb.sv
